// ===== hw/rtl/hfmm_pkg.sv =====
// Shared constants, codes and types of the value frequency histogram block.
package hfmm_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int COUNT_BITS  = 16;
    localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_BITS   = $clog2(TABLE_DEPTH + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    localparam logic [1:0] KIND_LIST = 2'd0;
    localparam logic [1:0] KIND_HIGH = 2'd1;
    localparam logic [1:0] KIND_LOW  = 2'd2;

    typedef enum logic [3:0] {
        ST_COLLECT = 4'b0001,
        ST_LIST    = 4'b0010,
        ST_HIGH    = 4'b0100,
        ST_LOW     = 4'b1000
    } state_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic        absorb;
        logic        rotate;
        logic [31:0] value;
    } cell_ctl_t;

endpackage

// ===== hw/rtl/hfmm_cell.sv =====
// One table cell: a stored key and its saturating count, linked into a ring.
module hfmm_cell (
    input  logic                           clk,
    input  hfmm_pkg::cell_ctl_t            ctl,
    input  logic                           occupied,
    input  logic                           alloc,
    input  logic [31:0]                    key_in,
    input  logic [hfmm_pkg::COUNT_BITS-1:0] count_in,
    output logic [31:0]                    key,
    output logic [hfmm_pkg::COUNT_BITS-1:0] count,
    output logic                           match
);

    logic [31:0]                     key_reg;
    logic [31:0]                     key_next;
    logic [hfmm_pkg::COUNT_BITS-1:0] count_reg;
    logic [hfmm_pkg::COUNT_BITS-1:0] count_next;

    assign match = occupied && (key_reg == ctl.value);
    assign key   = key_reg;
    assign count = count_reg;

    always_comb
    begin
        key_next   = key_reg;
        count_next = count_reg;
        if (ctl.rotate)
        begin
            key_next   = key_in;
            count_next = count_in;
        end
        else if (ctl.absorb)
        begin
            if (alloc)
            begin
                key_next   = ctl.value;
                count_next = hfmm_pkg::COUNT_ONE;
            end
            else if (match && (count_reg != hfmm_pkg::COUNT_MAX))
            begin
                count_next = count_reg + hfmm_pkg::COUNT_ONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        count_reg <= count_next;
    end

endmodule

// ===== hw/rtl/frequency_histogram_min_max.sv =====
// Top level of the value frequency histogram with highest- and lowest-count report.
//
// The block takes a data set of signed 32-bit values, one word per cycle, with
// tlast on the last value. Each value is compared against every table cell at
// once; a match bumps that cell's count (saturating at 2^COUNT_BITS-1), and a
// new value takes the first free cell. When the table is full, new values are
// dropped and the overflow flag of the report is set. After the last value the
// block stops accepting words and rotates the ring of cells past the head cell
// three times, one full turn of TABLE_DEPTH cells per pass, and pauses while
// the output is stalled. The first pass lists every value with its count
// (tuser 0) and finds the highest and lowest count, the second lists the
// values with the highest count (tuser 1), the third those with the lowest
// count (tuser 2), each in order of first appearance; tlast marks the final
// word of the report. The table then empties and collection resumes. The
// output word sits in its own register, so the last report word may still
// wait while the next data set is already being taken.
module frequency_histogram_min_max (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tlast,   // final_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [31:0] element, [47:32] count, [48] overflow
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // final_result
);

    localparam int DEPTH = hfmm_pkg::TABLE_DEPTH;
    localparam int CB    = hfmm_pkg::COUNT_BITS;
    localparam int IB    = hfmm_pkg::IDX_BITS;
    localparam int UB    = hfmm_pkg::USED_BITS;

    hfmm_pkg::state_t state_reg, state_next;
    logic [UB-1:0]    used_reg, used_next;
    logic             overflow_reg, overflow_next;
    logic [IB-1:0]    pos_reg, pos_next;
    logic [IB-1:0]    last_lo_reg, last_lo_next;
    logic [CB-1:0]    hi_reg, hi_next;
    logic [CB-1:0]    lo_reg, lo_next;

    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_elem_reg;
    logic [CB-1:0]    out_count_reg;
    logic             out_ovf_reg;
    logic [1:0]       out_kind_reg;
    logic             out_last_reg;

    hfmm_pkg::cell_ctl_t ctl;
    logic [DEPTH-1:0]    occ;
    logic [DEPTH-1:0]    alloc;
    logic [DEPTH-1:0]    match;
    logic [31:0]         keys   [DEPTH];
    logic [CB-1:0]       counts [DEPTH];

    logic          accept;
    logic          any_match;
    logic          head_valid;
    logic          emit;
    logic          advance;
    logic          wrap;
    logic [31:0]   head_key;
    logic [CB-1:0] head_count;
    logic [31:0]   count_wide;

    assign s_axis_tready = (state_reg == hfmm_pkg::ST_COLLECT);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign any_match     = |match;

    assign ctl.absorb = accept;
    assign ctl.rotate = (state_reg != hfmm_pkg::ST_COLLECT) && advance;
    assign ctl.value  = s_axis_tdata;

    // Cells fill in order, so the fill count tells which are in use, and a
    // new value goes to the cell just past the last used one.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign occ[gi] = (used_reg > UB'(gi));
            if (gi == 0)
            begin : g_head
                assign alloc[gi] = !any_match && !occ[gi];
            end
            else
            begin : g_body
                assign alloc[gi] = !any_match && !occ[gi] && occ[gi-1];
            end

            hfmm_cell u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .occupied (occ[gi]),
                .alloc    (alloc[gi]),
                .key_in   (keys[(gi + 1) % DEPTH]),
                .count_in (counts[(gi + 1) % DEPTH]),
                .key      (keys[gi]),
                .count    (counts[gi]),
                .match    (match[gi])
            );
        end
    endgenerate

    // During a report the entry at position pos_reg of the table sits in cell 0.
    assign head_key   = keys[0];
    assign head_count = counts[0];
    assign head_valid = (UB'(pos_reg) < used_reg);
    assign wrap       = (pos_reg == IB'(DEPTH - 1));

    always_comb
    begin
        case (state_reg)
            hfmm_pkg::ST_LIST: emit = head_valid;
            hfmm_pkg::ST_HIGH: emit = head_valid && (head_count == hi_reg);
            hfmm_pkg::ST_LOW:  emit = head_valid && (head_count == lo_reg);
            default:           emit = 1'b0;
        endcase
    end

    assign advance = !emit || !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        overflow_next  = overflow_reg;
        pos_next       = pos_reg;
        last_lo_next   = last_lo_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (emit && advance)
        begin
            out_valid_next = 1'b1;
        end

        case (state_reg)
            hfmm_pkg::ST_COLLECT:
            begin
                if (accept)
                begin
                    if (|alloc)
                    begin
                        used_next = used_reg + UB'(1);
                    end
                    else if (!any_match)
                    begin
                        overflow_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        state_next = hfmm_pkg::ST_LIST;
                        pos_next   = '0;
                    end
                end
            end
            hfmm_pkg::ST_LIST:
            begin
                if (advance)
                begin
                    if (head_valid)
                    begin
                        if (pos_reg == '0)
                        begin
                            hi_next = head_count;
                            lo_next = head_count;
                        end
                        else
                        begin
                            if (head_count > hi_reg)
                            begin
                                hi_next = head_count;
                            end
                            if (head_count < lo_reg)
                            begin
                                lo_next = head_count;
                            end
                        end
                    end
                    pos_next = wrap ? '0 : pos_reg + IB'(1);
                    if (wrap)
                    begin
                        state_next = hfmm_pkg::ST_HIGH;
                    end
                end
            end
            hfmm_pkg::ST_HIGH:
            begin
                if (advance)
                begin
                    // Find where the lowest-count run ends so tlast can be set.
                    if (head_valid && (head_count == lo_reg))
                    begin
                        last_lo_next = pos_reg;
                    end
                    pos_next = wrap ? '0 : pos_reg + IB'(1);
                    if (wrap)
                    begin
                        state_next = hfmm_pkg::ST_LOW;
                    end
                end
            end
            hfmm_pkg::ST_LOW:
            begin
                if (advance)
                begin
                    pos_next = wrap ? '0 : pos_reg + IB'(1);
                    if (wrap)
                    begin
                        state_next    = hfmm_pkg::ST_COLLECT;
                        used_next     = '0;
                        overflow_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = hfmm_pkg::ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hfmm_pkg::ST_COLLECT;
            used_reg      <= '0;
            overflow_reg  <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            overflow_reg  <= overflow_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_lo_reg <= last_lo_next;
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        if (emit && advance)
        begin
            out_elem_reg  <= head_key;
            out_count_reg <= head_count;
            out_ovf_reg   <= overflow_reg;
            case (state_reg)
                hfmm_pkg::ST_HIGH: out_kind_reg <= hfmm_pkg::KIND_HIGH;
                hfmm_pkg::ST_LOW:  out_kind_reg <= hfmm_pkg::KIND_LOW;
                default:           out_kind_reg <= hfmm_pkg::KIND_LIST;
            endcase
            out_last_reg <= (state_reg == hfmm_pkg::ST_LOW) && (pos_reg == last_lo_reg);
        end
    end

    // The reported count is the low 16 bits of the stored count.
    assign count_wide    = 32'(out_count_reg);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_ovf_reg, count_wide[15:0], out_elem_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // While a report runs the ring is rotated, so stale keys of earlier data
    // sets can sit in the cells marked in use; matches only count in collection.
`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UB'(DEPTH))
        else $error("fill count exceeds table depth");

    a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> $onehot0(match))
        else $error("value stored in more than one cell");

    a_one_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> $onehot0(alloc))
        else $error("more than one cell claimed for a new value");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (used_reg == UB'(DEPTH)))
        else $error("overflow flagged while table not full");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == hfmm_pkg::KIND_LOW))
        else $error("report ended outside the lowest-count run");
`endif

endmodule

// ===== bench/frequency_histogram_min_max_test.sv =====
// Self-checking testbench for the value frequency histogram with highest- and lowest-count report.
module frequency_histogram_min_max_test;

    // Run shape.
    localparam int RANDOM_ITEMS   = 500;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 3 * hfmm_pkg::TABLE_DEPTH + 16;
    localparam int TIMEOUT_CYCLES = 1000000;

    // One word of the report as the block should present it.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] element;
        logic [15:0] count;
        logic        overflow;
        logic        final_result;
    } report_word_t;

    // One row of the directed table. Rows marked typed carry the count of the
    // only distinct value of their data set; the three report words of such a
    // set are written out here instead of being taken from the predictor.
    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic        typed;
        logic [15:0] count;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] value
    logic        s_axis_tlast;   // final_item
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // [31:0] element, [47:32] count, [48] overflow
    logic [1:0]  m_axis_tuser;   // [1:0] kind
    logic        m_axis_tlast;   // final_result

    // The predictor keeps its own copy of the table in order of first appearance.
    logic [31:0]                     hist_keys   [hfmm_pkg::TABLE_DEPTH];
    logic [hfmm_pkg::COUNT_BITS-1:0] hist_counts [hfmm_pkg::TABLE_DEPTH];
    int                              hist_used    = 0;
    logic                            hist_dropped = 1'b0;

    report_word_t predicted_words[$];
    report_word_t report_queue[$];

    int errors        = 0;
    bit hold_off_req  = 1'b0;
    bit burst_mode    = 1'b0;

    // Directed part: single-value sets at both extremes of the value range
    // right after reset, a small mixed set with one clear mode, and a set
    // that overfills the table. In the last one a new value is dropped once
    // the table is full, and the final word repeats a stored value, which
    // must still be counted.
    stim_row_t directed_rows [0:23] = '{
        '{32'h8000_0000, 1'b1, 1'b1, 16'd1},
        '{32'h7FFF_FFFF, 1'b1, 1'b1, 16'd1},
        '{32'h0000_0005, 1'b0, 1'b0, 16'd0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0},
        '{32'h0000_0005, 1'b0, 1'b0, 16'd0},
        '{32'h0000_0007, 1'b1, 1'b0, 16'd0},
        '{32'h0000_0000, 1'b0, 1'b0, 16'd0},
        '{32'h1111_1111, 1'b0, 1'b0, 16'd0},
        '{32'h2222_2222, 1'b0, 1'b0, 16'd0},
        '{32'h3333_3333, 1'b0, 1'b0, 16'd0},
        '{32'h4444_4444, 1'b0, 1'b0, 16'd0},
        '{32'h5555_5555, 1'b0, 1'b0, 16'd0},
        '{32'h6666_6666, 1'b0, 1'b0, 16'd0},
        '{32'h7777_7777, 1'b0, 1'b0, 16'd0},
        '{32'h8888_8888, 1'b0, 1'b0, 16'd0},
        '{32'h9999_9999, 1'b0, 1'b0, 16'd0},
        '{32'hAAAA_AAAA, 1'b0, 1'b0, 16'd0},
        '{32'hBBBB_BBBB, 1'b0, 1'b0, 16'd0},
        '{32'hCCCC_CCCC, 1'b0, 1'b0, 16'd0},
        '{32'hDDDD_DDDD, 1'b0, 1'b0, 16'd0},
        '{32'hEEEE_EEEE, 1'b0, 1'b0, 16'd0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0},
        '{32'h1234_5678, 1'b0, 1'b0, 16'd0},
        '{32'h3333_3333, 1'b1, 1'b0, 16'd0}
    };

    frequency_histogram_min_max u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Most gaps are empty or short; a few are long enough to let the
    // other side run ahead.
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic report_word_t make_word(input logic [1:0] kind,
                                               input logic [31:0] element,
                                               input logic [hfmm_pkg::COUNT_BITS-1:0] count,
                                               input logic overflow,
                                               input logic final_result);
        report_word_t w;
        w.kind         = kind;
        w.element      = element;
        w.count        = 16'(count);
        w.overflow     = overflow;
        w.final_result = final_result;
        return w;
    endfunction

    // Counts one value into the predictor's table. On the last value of a
    // data set it fills predicted_words with the three runs of the report
    // and empties the table.
    task automatic tally_value(input logic [31:0] v, input logic last);
        int slot;
        int total;
        int k;
        int i;
        logic [hfmm_pkg::COUNT_BITS-1:0] top;
        logic [hfmm_pkg::COUNT_BITS-1:0] bottom;
        predicted_words.delete();
        slot = -1;
        for (i = 0; i < hist_used; i++)
            if (hist_keys[i] == v)
                slot = i;
        if (slot >= 0)
        begin
            // A stored value keeps counting until the ceiling, then stays there.
            if (hist_counts[slot] != hfmm_pkg::COUNT_MAX)
                hist_counts[slot] = hist_counts[slot] + hfmm_pkg::COUNT_ONE;
        end
        else if (hist_used < hfmm_pkg::TABLE_DEPTH)
        begin
            hist_keys[hist_used]   = v;
            hist_counts[hist_used] = hfmm_pkg::COUNT_ONE;
            hist_used++;
        end
        else
            hist_dropped = 1'b1;

        if (last)
        begin
            top    = hist_counts[0];
            bottom = hist_counts[0];
            for (i = 1; i < hist_used; i++)
            begin
                if (hist_counts[i] > top)
                    top = hist_counts[i];
                if (hist_counts[i] < bottom)
                    bottom = hist_counts[i];
            end
            total = hist_used;
            for (i = 0; i < hist_used; i++)
            begin
                if (hist_counts[i] == top)
                    total++;
                if (hist_counts[i] == bottom)
                    total++;
            end
            k = 0;
            for (i = 0; i < hist_used; i++)
            begin
                predicted_words = {predicted_words,
                                   make_word(hfmm_pkg::KIND_LIST, hist_keys[i], hist_counts[i],
                                             hist_dropped, k == total - 1)};
                k++;
            end
            for (i = 0; i < hist_used; i++)
                if (hist_counts[i] == top)
                begin
                    predicted_words = {predicted_words,
                                       make_word(hfmm_pkg::KIND_HIGH, hist_keys[i],
                                                 hist_counts[i], hist_dropped, k == total - 1)};
                    k++;
                end
            for (i = 0; i < hist_used; i++)
                if (hist_counts[i] == bottom)
                begin
                    predicted_words = {predicted_words,
                                       make_word(hfmm_pkg::KIND_LOW, hist_keys[i],
                                                 hist_counts[i], hist_dropped, k == total - 1)};
                    k++;
                end
            hist_used    = 0;
            hist_dropped = 1'b0;
        end
    endtask

    // Offers one word after a random gap and holds it until the block takes
    // it. The valid line is only lowered when a gap follows, so back-to-back
    // words keep it high without a glitch.
    task automatic send_word(input logic [31:0] v, input logic last,
                             input logic typed, input logic [15:0] typed_count);
        int gap;
        gap = burst_mode ? 0 : idle_cycles();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);

        tally_value(v, last);
        if (typed)
            report_queue = {report_queue,
                            make_word(hfmm_pkg::KIND_LIST, v, typed_count, 1'b0, 1'b0),
                            make_word(hfmm_pkg::KIND_HIGH, v, typed_count, 1'b0, 1'b0),
                            make_word(hfmm_pkg::KIND_LOW,  v, typed_count, 1'b0, 1'b1)};
        else
            report_queue = {report_queue, predicted_words};
    endtask

    // Stops offering words until every expected report word has arrived.
    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (report_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
        end
    endtask

    // Sender side: reset, the directed table, then random data sets until
    // about RANDOM_ITEMS words have gone in.
    initial
    begin : stimulus
        logic [31:0] pool [24];
        int          set_idx;
        int          set_len;
        int          pool_size;
        int          sent;
        int          n;
        int          i;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            send_word(directed_rows[r].value, directed_rows[r].last,
                      directed_rows[r].typed, directed_rows[r].count);

        // Ask the receiver for one long hold while data sets keep coming,
        // so that a report backs up and the input stalls. The first sets
        // never wait for the reports, so words are offered during the hold.
        hold_off_req <= 1'b1;
        sent    = 0;
        set_idx = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (set_idx == 5 || (set_idx > 5 && $urandom_range(0, 11) == 0))
                drain_reports();
            burst_mode = ($urandom_range(0, 7) == 0);
            // Most sets are short and drawn from a few values so that counts
            // repeat; some are long enough with enough values to overfill.
            if ($urandom_range(0, 7) == 0)
            begin
                set_len   = $urandom_range(17, 30);
                pool_size = 24;
            end
            else
            begin
                set_len   = $urandom_range(1, 12);
                pool_size = $urandom_range(1, 6);
            end
            for (i = 0; i < pool_size; i++)
                case ($urandom_range(0, 9))
                    0:       pool[i] = 32'h8000_0000;
                    1:       pool[i] = 32'h7FFF_FFFF;
                    2:       pool[i] = 32'hFFFF_FFFF;
                    3:       pool[i] = 32'h0000_0000;
                    default: pool[i] = $urandom();
                endcase
            for (n = 0; n < set_len; n++)
                send_word(pool[$urandom_range(0, pool_size - 1)], n == set_len - 1,
                          1'b0, 16'd0);
            sent += set_len;
            set_idx++;
        end
        burst_mode = 1'b0;

        drain_reports();
        // Any word beyond the expected ones shows up here as unexpected.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Receiver side: random ready gaps with calm stretches, one long hold
    // when asked, and a field-by-field check of every word taken.
    initial
    begin : sink
        report_word_t want;
        int           gap;
        int           calm_left;
        bit           held;
        m_axis_tready <= 1'b0;
        calm_left = 0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req && !held)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (calm_left > 0)
                begin
                    calm_left--;
                    gap = 0;
                end
                else
                begin
                    gap = idle_cycles();
                    if ($urandom_range(0, 19) == 0)
                        calm_left = $urandom_range(10, 60);
                end
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_axis_tvalid !== 1'b1);

            if (report_queue.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word: expected none, actual tdata %h tuser %0d tlast %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                want = report_queue.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("element", want.element, m_axis_tdata[31:0]);
                check_field("count", 32'(want.count), 32'(m_axis_tdata[47:32]));
                check_field("overflow", 32'(want.overflow), 32'(m_axis_tdata[48]));
                check_field("padding", 32'd0, 32'(m_axis_tdata[55:49]));
                check_field("final_result", 32'(want.final_result), 32'(m_axis_tlast));
            end
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * 20);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/hfmm_pkg.sv
hw/rtl/hfmm_cell.sv
hw/rtl/frequency_histogram_min_max.sv
bench/frequency_histogram_min_max_test.sv
